// ----- sv/rhc_pkg.sv -----
package rhc_pkg;

	// Which channel holds the maximum; red wins ties, then green
	typedef logic [1:0] sector_t;

	localparam sector_t SECTOR_RED   = 2'd0;
	localparam sector_t SECTOR_GREEN = 2'd1;
	localparam sector_t SECTOR_BLUE  = 2'd2;

endpackage

// ----- sv/rgb_to_hsv_convert.sv -----
// Pipeline: stage 1 (max, min, sector), stage 2 (delta and numerators), the
// divide stages and the result register.
// Throughput: one item per clock while out_stall stays low; each quotient bit of
// the hue and saturation dividers has its own stage; bubbles close up under stall.
// Reset: arst_n clears all stage valid bits at once; no data is cleared.
module rgb_to_hsv_convert #(
	parameter int CHANNEL_BITS = 8,
	parameter int HUE_BITS     = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CHANNEL_BITS-1:0] red,
	input  logic [CHANNEL_BITS-1:0] green,
	input  logic [CHANNEL_BITS-1:0] blue,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [HUE_BITS-1:0]     hue_turn,
	output logic [CHANNEL_BITS-1:0] saturation_out,
	output logic [CHANNEL_BITS-1:0] value_out,
	output logic                    hue_undefined
);

	localparam int CB    = CHANNEL_BITS;
	localparam int DW    = CHANNEL_BITS + 3;  // holds 6 * delta
	localparam int NW    = CHANNEL_BITS + 4;  // signed hue numerator
	localparam int NDIV  = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;
	localparam int H_OFF = NDIV - HUE_BITS;
	localparam int S_OFF = NDIV - CHANNEL_BITS;
	localparam int NST   = NDIV + 3;          // s1, s2, divide stages, output

	// stage valid bits and per-stage advance
	logic [NST-1:0] vld_s;
	logic [NST-1:0] adv;

	// flow control: a stage moves when it is empty or the next one moves
	assign adv[NST-1] = !vld_s[NST-1] || !out_stall;
	for (genvar i = 0; i < NST - 1; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	assign in_stall  = !adv[0];
	assign out_valid = vld_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// ---------------- stage 1: max, min and sector ----------------
	rhc_pkg::sector_t sec_c;
	logic [CB-1:0]    mx_c;
	logic [CB-1:0]    mn_c;

	always_comb begin
		if (red >= green && red >= blue) begin
			sec_c = rhc_pkg::SECTOR_RED;
			mx_c  = red;
		end else if (green >= blue) begin
			sec_c = rhc_pkg::SECTOR_GREEN;
			mx_c  = green;
		end else begin
			sec_c = rhc_pkg::SECTOR_BLUE;
			mx_c  = blue;
		end
		mn_c = red;
		if (green < mn_c) mn_c = green;
		if (blue < mn_c) mn_c = blue;
	end

	rhc_pkg::sector_t sec_s1;
	logic [CB-1:0]    red_s1;
	logic [CB-1:0]    green_s1;
	logic [CB-1:0]    blue_s1;
	logic [CB-1:0]    mx_s1;
	logic [CB-1:0]    mn_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			sec_s1   <= sec_c;
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
			mx_s1    <= mx_c;
			mn_s1    <= mn_c;
		end
	end

	// ---------------- stage 2: delta, hue numerator, sat numerator ----------------
	logic [CB-1:0]        delta_c;
	logic signed [NW-1:0] d_e, r_e, g_e, b_e, den_e, num_c;
	logic [2*CB-1:0]      snum_c;

	always_comb begin
		delta_c = mx_s1 - mn_s1;
		d_e     = $signed({4'b0000, delta_c});
		r_e     = $signed({4'b0000, red_s1});
		g_e     = $signed({4'b0000, green_s1});
		b_e     = $signed({4'b0000, blue_s1});
		den_e   = (d_e <<< 2) + (d_e <<< 1);
		case (sec_s1)
			rhc_pkg::SECTOR_RED:   num_c = g_e - b_e;
			rhc_pkg::SECTOR_GREEN: num_c = (d_e <<< 1) + b_e - r_e;
			rhc_pkg::SECTOR_BLUE:  num_c = (d_e <<< 2) + r_e - g_e;
			default:               num_c = '0;
		endcase
		// wrap into one full turn
		if (num_c < 0) begin
			num_c = num_c + den_e;
		end
		// delta * CHMAX without a multiplier
		snum_c = {delta_c, {CB{1'b0}}} - {{CB{1'b0}}, delta_c};
	end

	// divide pipeline, index 0 is stage 2, index k+1 follows divide step k
	logic [DW-1:0]       hrem_sd  [0:NDIV];
	logic [DW-1:0]       hden_sd  [0:NDIV];
	logic [HUE_BITS-1:0] hquo_sd  [0:NDIV];
	logic [CB-1:0]       srem_sd  [0:NDIV];
	logic [CB-1:0]       sden_sd  [0:NDIV];
	logic [CB-1:0]       slo_sd   [0:NDIV];
	logic [CB-1:0]       squo_sd  [0:NDIV];
	logic                gray_sd  [0:NDIV];
	logic                undef_sd [0:NDIV];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			hrem_sd[0]  <= num_c[DW-1:0];
			hden_sd[0]  <= den_e[DW-1:0];
			hquo_sd[0]  <= '0;
			srem_sd[0]  <= snum_c[2*CB-1:CB];
			sden_sd[0]  <= mx_s1;
			slo_sd[0]   <= snum_c[CB-1:0];
			squo_sd[0]  <= '0;
			gray_sd[0]  <= (delta_c == '0);
			undef_sd[0] <= (mx_s1 == '0);
		end
	end

	// ---------------- divide stages: one quotient bit each ----------------
	for (genvar k = 0; k < NDIV; k++) begin : g_div
		logic [DW-1:0] hrem_nx;
		logic          hq;
		logic [CB-1:0] srem_nx;
		logic [CB-1:0] slo_nx;
		logic          sq;

		// hue lane: zeros shift in, quotient gets HUE_BITS bits
		if (k >= H_OFF) begin : g_h
			rhc_div_step #(.W(DW)) u_hstep (
				.rem    (hrem_sd[k]),
				.den    (hden_sd[k]),
				.shin   (1'b0),
				.rem_nx (hrem_nx),
				.qbit   (hq)
			);
		end else begin : g_hp
			assign hrem_nx = hrem_sd[k];
			assign hq      = 1'b0;
		end

		// saturation lane: low numerator bits shift in MSB first
		if (k >= S_OFF) begin : g_s
			rhc_div_step #(.W(CB)) u_sstep (
				.rem    (srem_sd[k]),
				.den    (sden_sd[k]),
				.shin   (slo_sd[k][CB-1]),
				.rem_nx (srem_nx),
				.qbit   (sq)
			);
			assign slo_nx = {slo_sd[k][CB-2:0], 1'b0};
		end else begin : g_sp
			assign srem_nx = srem_sd[k];
			assign sq      = 1'b0;
			assign slo_nx  = slo_sd[k];
		end

		// idle lanes shift zeros into a zero quotient, so shifting always is safe
		always_ff @(posedge clk) begin
			if (adv[k+2]) begin
				hrem_sd[k+1]  <= hrem_nx;
				hden_sd[k+1]  <= hden_sd[k];
				hquo_sd[k+1]  <= {hquo_sd[k][HUE_BITS-2:0], hq};
				srem_sd[k+1]  <= srem_nx;
				sden_sd[k+1]  <= sden_sd[k];
				slo_sd[k+1]   <= slo_nx;
				squo_sd[k+1]  <= {squo_sd[k][CB-2:0], sq};
				gray_sd[k+1]  <= gray_sd[k];
				undef_sd[k+1] <= undef_sd[k];
			end
		end
	end

	// ---------------- output register: special cases ----------------
	logic [HUE_BITS-1:0] hue_q;
	logic [CB-1:0]       sat_q;
	logic [CB-1:0]       val_q;
	logic                undef_q;

	always_ff @(posedge clk) begin
		if (adv[NST-1]) begin
			hue_q   <= (gray_sd[NDIV] || undef_sd[NDIV]) ? '0 : hquo_sd[NDIV];
			sat_q   <= undef_sd[NDIV] ? '0 : squo_sd[NDIV];
			val_q   <= sden_sd[NDIV];
			undef_q <= undef_sd[NDIV];
		end
	end

	assign hue_turn       = hue_q;
	assign saturation_out = sat_q;
	assign value_out      = val_q;
	assign hue_undefined  = undef_q;

	// ---------------- assertions ----------------
	// input stalls only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_s))
		else $error("input stalled with a bubble in the pipeline");

	// black pixel gives all-zero results
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hue_undefined) |->
		(hue_turn == '0 && saturation_out == '0 && value_out == '0))
		else $error("undefined hue with nonzero result");

	// wrapped hue numerator stays below the divisor
	a_hue_num: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && hden_sd[0] != '0) |-> (hrem_sd[0] < hden_sd[0]))
		else $error("hue numerator not wrapped into one turn");

	// saturation divide starts with a remainder below max
	a_sat_num: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[1] && !undef_sd[0]) |-> (srem_sd[0] < sden_sd[0]))
		else $error("saturation numerator out of range");

endmodule

// ----- sv/rhc_div_step.sv -----
// One restoring division step: shift one bit into the remainder, then
// subtract the divisor when it fits. Remainder in must be below den.
module rhc_div_step #(
	parameter int W = 8
) (
	input  logic [W-1:0] rem,
	input  logic [W-1:0] den,
	input  logic         shin,
	output logic [W-1:0] rem_nx,
	output logic         qbit
);

	logic [W:0] trial;
	logic [W:0] diff;

	assign trial  = {rem, shin};
	assign diff   = trial - {1'b0, den};
	assign qbit   = (trial >= {1'b0, den});
	assign rem_nx = qbit ? diff[W-1:0] : trial[W-1:0];

endmodule

// ----- dv/rgb_to_hsv_convert_tb.sv -----
`timescale 1ns / 1ps

module rgb_to_hsv_convert_tb;

	localparam int CHANNEL_BITS = 8;
	localparam int HUE_BITS     = 16;
	localparam int CHANNEL_MAX  = (1 << CHANNEL_BITS) - 1;
	localparam int RANDOM_ITEMS = 1200;
	localparam int LONG_HOLD    = 300;
	localparam int DRAIN_CYCLES = 64;
	localparam int SHOW_LIMIT   = 100;

	typedef logic [CHANNEL_BITS-1:0] chan_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
	} pixel_t;

	typedef struct packed {
		logic [HUE_BITS-1:0] hue;
		chan_t               sat;
		chan_t               value;
		logic                undef;
	} hsv_t;

	typedef struct packed {
		pixel_t px;
		logic   fixed;
		hsv_t   typed;
	} stim_row_t;

	typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_FULL} idle_mode_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	chan_t               red;
	chan_t               green;
	chan_t               blue;
	logic                out_valid;
	logic                out_stall;
	logic [HUE_BITS-1:0] hue_turn;
	chan_t               saturation_out;
	chan_t               value_out;
	logic                hue_undefined;

	hsv_t       pending_hsv[$];
	stim_row_t  directed_rows[$];
	int         mismatch_count = 0;
	idle_mode_t tx_mode = IDLE_NONE;
	idle_mode_t rx_mode = IDLE_FULL;
	bit         long_hold = 1'b0;

	rgb_to_hsv_convert #(
		.CHANNEL_BITS(CHANNEL_BITS),
		.HUE_BITS    (HUE_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hue_turn      (hue_turn),
		.saturation_out(saturation_out),
		.value_out     (value_out),
		.hue_undefined (hue_undefined)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("rgb_to_hsv_convert_tb: done, errors");
		$finish;
	end

	// Expected HSV for one pixel, exact integer arithmetic
	function automatic hsv_t convert_pixel(pixel_t px);
		chan_t            hi;
		chan_t            lo;
		chan_t            spread;
		rhc_pkg::sector_t sector;
		int               offset;
		int               sat;
		longint           hue;
		hsv_t             h;
		hi = px.r;
		if (px.g > hi) hi = px.g;
		if (px.b > hi) hi = px.b;
		lo = px.r;
		if (px.g < lo) lo = px.g;
		if (px.b < lo) lo = px.b;
		spread = hi - lo;
		// red wins ties, then green
		if (px.r == hi) sector = rhc_pkg::SECTOR_RED;
		else if (px.g == hi) sector = rhc_pkg::SECTOR_GREEN;
		else sector = rhc_pkg::SECTOR_BLUE;
		h = '0;
		h.value = hi;
		if (hi == 0) begin
			h.undef = 1'b1;
		end else begin
			sat = (int'(spread) * CHANNEL_MAX) / int'(hi);
			h.sat = sat[CHANNEL_BITS-1:0];
			// gray pixel: no spread, hue stays zero
			if (spread != 0) begin
				case (sector)
					rhc_pkg::SECTOR_RED: begin
						offset = int'(px.g) - int'(px.b);
					end
					rhc_pkg::SECTOR_GREEN: begin
						offset = 2 * int'(spread) + int'(px.b) - int'(px.r);
					end
					default: begin
						offset = 4 * int'(spread) + int'(px.r) - int'(px.g);
					end
				endcase
				if (offset < 0) offset += 6 * int'(spread);
				hue = (longint'(offset) << HUE_BITS) / longint'(6 * int'(spread));
				h.hue = hue[HUE_BITS-1:0];
			end
		end
		return h;
	endfunction

	function automatic int draw_wait(idle_mode_t mode);
		case (mode)
			IDLE_NONE:  return 0;
			IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
			default:    return $urandom_range(0, 14);
		endcase
	endfunction

	// Small step around a level, clamped to the channel range
	function automatic chan_t nudge(chan_t v);
		int t;
		t = int'(v) + $urandom_range(0, 4) - 2;
		if (t < 0) t = 0;
		if (t > CHANNEL_MAX) t = CHANNEL_MAX;
		return chan_t'(t);
	endfunction

	function automatic chan_t extreme_or(chan_t v);
		case ($urandom_range(0, 2))
			0:       return '0;
			1:       return '1;
			default: return v;
		endcase
	endfunction

	// Random pixel, weighted toward gray, near gray, ties, extremes, tiny values and a zero channel
	function automatic pixel_t make_pixel();
		pixel_t px;
		int     roll;
		chan_t  level;
		roll  = $urandom_range(0, 99);
		level = chan_t'($urandom);
		px.r  = chan_t'($urandom);
		px.g  = chan_t'($urandom);
		px.b  = chan_t'($urandom);
		if (roll < 10) begin
			px = {level, level, level};
		end else if (roll < 22) begin
			px.g = nudge(px.r);
			px.b = nudge(px.r);
		end else if (roll < 36) begin
			case ($urandom_range(0, 2))
				0:       px.g = px.r;
				1:       px.b = px.r;
				default: px.b = px.g;
			endcase
		end else if (roll < 48) begin
			px.r = extreme_or(px.r);
			px.g = extreme_or(px.g);
			px.b = extreme_or(px.b);
		end else if (roll < 56) begin
			px.r = chan_t'($urandom_range(0, 3));
			px.g = chan_t'($urandom_range(0, 3));
			px.b = chan_t'($urandom_range(0, 3));
		end else if (roll < 64) begin
			case ($urandom_range(0, 2))
				0:       px.r = '0;
				1:       px.g = '0;
				default: px.b = '0;
			endcase
		end
		return px;
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		if (mismatch_count < SHOW_LIMIT)
			$display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic fixed_row(chan_t r, chan_t g, chan_t b, int hue, int sat, int value,
			bit undef);
		stim_row_t row;
		row.px          = {r, g, b};
		row.fixed       = 1'b1;
		row.typed.hue   = hue[HUE_BITS-1:0];
		row.typed.sat   = sat[CHANNEL_BITS-1:0];
		row.typed.value = value[CHANNEL_BITS-1:0];
		row.typed.undef = undef;
		directed_rows.push_back(row);
	endtask

	task automatic plain_row(chan_t r, chan_t g, chan_t b);
		stim_row_t row;
		row.px    = {r, g, b};
		row.fixed = 1'b0;
		row.typed = '0;
		directed_rows.push_back(row);
	endtask

	// Offer one item; starts and ends at a falling edge
	task automatic offer_pixel(pixel_t px, logic fixed, hsv_t typed);
		int gap;
		gap = draw_wait(tx_mode);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) begin
				red   <= chan_t'($urandom);
				green <= chan_t'($urandom);
				blue  <= chan_t'($urandom);
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		red      <= px.r;
		green    <= px.g;
		blue     <= px.b;
		do @(posedge clk); while (in_stall !== 1'b0);
		pending_hsv.push_back(fixed ? typed : convert_pixel(px));
		@(negedge clk);
	endtask

	// Stimulus and end of run
	initial begin : stimulus
		int phase;
		in_valid <= 1'b0;
		red      <= '0;
		green    <= '0;
		blue     <= '0;
		arst_n   <= 1'b0;

		// black, grays, primaries: read straight off the definition
		fixed_row(8'd0,   8'd0,   8'd0,   0,     0,   0,   1'b1);
		fixed_row(8'd255, 8'd255, 8'd255, 0,     0,   255, 1'b0);
		fixed_row(8'd1,   8'd1,   8'd1,   0,     0,   1,   1'b0);
		fixed_row(8'd128, 8'd128, 8'd128, 0,     0,   128, 1'b0);
		fixed_row(8'd255, 8'd0,   8'd0,   0,     255, 255, 1'b0);
		fixed_row(8'd0,   8'd255, 8'd0,   21845, 255, 255, 1'b0);
		fixed_row(8'd0,   8'd0,   8'd255, 43690, 255, 255, 1'b0);
		fixed_row(8'd1,   8'd0,   8'd0,   0,     255, 1,   1'b0);
		// ties, hue wrap below zero, near-gray and mixed colors
		plain_row(8'd255, 8'd255, 8'd0);
		plain_row(8'd255, 8'd0,   8'd255);
		plain_row(8'd0,   8'd255, 8'd255);
		plain_row(8'd255, 8'd0,   8'd1);
		plain_row(8'd255, 8'd1,   8'd0);
		plain_row(8'd1,   8'd255, 8'd0);
		plain_row(8'd0,   8'd1,   8'd255);
		plain_row(8'd254, 8'd255, 8'd255);
		plain_row(8'd255, 8'd254, 8'd254);
		plain_row(8'd0,   8'd0,   8'd1);
		plain_row(8'd170, 8'd85,  8'd0);
		plain_row(8'd85,  8'd170, 8'd255);
		plain_row(8'd255, 8'd128, 8'd0);
		plain_row(8'd127, 8'd128, 8'd129);
		plain_row(8'd200, 8'd100, 8'd150);
		plain_row(8'd1,   8'd2,   8'd3);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer_pixel(directed_rows[i].px, directed_rows[i].fixed, directed_rows[i].typed);

		// random part in phases of 100 items, sender idling rotates per phase
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0) begin
				phase   = n / 100;
				tx_mode = idle_mode_t'(phase % 3);
				// back pressure: receiver holds off while we keep feeding
				if (phase == 3 || phase == 8) begin
					tx_mode   = IDLE_NONE;
					long_hold = 1'b1;
				end
			end
			offer_pixel(make_pixel(), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("rgb_to_hsv_convert_tb: done, clean");
		else
			$display("rgb_to_hsv_convert_tb: done, errors");
		$finish;
	end

	// Result side: random stall before each item, plus the long hold on request
	initial begin : result_sink
		int hold;
		int taken;
		taken = 0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				hold      = LONG_HOLD;
			end else begin
				hold = draw_wait(rx_mode);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
			taken++;
			if (taken % 64 == 0) rx_mode = idle_mode_t'((int'(rx_mode) + 1) % 3);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		hsv_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_hsv.size() == 0) begin
				flag_mismatch("unexpected result, hue_turn", longint'(hue_turn),
					longint'(-1));
			end else begin
				want = pending_hsv.pop_front();
				if (hue_turn !== want.hue)
					flag_mismatch("hue_turn", longint'(hue_turn), longint'(want.hue));
				if (saturation_out !== want.sat)
					flag_mismatch("saturation_out", longint'(saturation_out),
						longint'(want.sat));
				if (value_out !== want.value)
					flag_mismatch("value_out", longint'(value_out), longint'(want.value));
				if (hue_undefined !== want.undef)
					flag_mismatch("hue_undefined", longint'(hue_undefined),
						longint'(want.undef));
			end
		end
	end

endmodule
